// File: rtl/gpc_pkg.sv
// ----------------------------------------------------------------------------
// GPIO pin controller package
// Request and response types, word map and field codes shared by the
// GPIO pin controller and its address decoder.
// ----------------------------------------------------------------------------
package gpc_pkg;

	localparam int FIELD_W = 58;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 6;

	// Word map (byte offsets divided by four).
	localparam logic [ADDR_W-1:0] W_SET0    = ADDR_W'(32'h001C / 4);
	localparam logic [ADDR_W-1:0] W_SET1    = ADDR_W'(32'h001C / 4 + 1);
	localparam logic [ADDR_W-1:0] W_CLR0    = ADDR_W'(32'h0028 / 4);
	localparam logic [ADDR_W-1:0] W_CLR1    = ADDR_W'(32'h0028 / 4 + 1);
	localparam logic [ADDR_W-1:0] W_LEV0    = ADDR_W'(32'h0034 / 4);
	localparam logic [ADDR_W-1:0] W_LEV1    = ADDR_W'(32'h0034 / 4 + 1);
	localparam logic [ADDR_W-1:0] W_PUD     = ADDR_W'(32'h0094 / 4);
	localparam logic [ADDR_W-1:0] W_PUDCLK0 = ADDR_W'(32'h0098 / 4);
	localparam logic [ADDR_W-1:0] W_PUDCLK1 = ADDR_W'(32'h0098 / 4 + 1);
	localparam logic [ADDR_W-1:0] W_PUP0    = ADDR_W'(32'h00E4 / 4);

	// Function select and pull codes.
	localparam int FSEL_W = 3;
	localparam int PULL_W = 2;
	localparam logic [FSEL_W-1:0] FSEL_FULL   = 3'h7;
	localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'd1;
	localparam logic [PULL_W-1:0] PULL_MASK   = 2'h3;
	localparam logic [PULL_W-1:0] PULL_UP     = 2'd1;
	localparam logic [PULL_W-1:0] PULL_DOWN   = 2'd2;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// Largest layout over the supported pin counts (up to 64 pins).
	localparam int FSEL_PINS_PER_WORD = 10;
	localparam int PULL_PINS_PER_WORD = 16;
	localparam int FSEL_PAD_PINS      = 70;
	localparam int MAX_PINS           = 64;

	typedef struct packed {
		logic               req_type;
		logic [ADDR_W-1:0]  word_addr;
		logic [DATA_W-1:0]  write_data;
		logic [FIELD_W-1:0] pad_levels;
	} gpc_req_t;

	typedef struct packed {
		logic [DATA_W-1:0]  read_data;
		logic               unmapped;
		logic [FIELD_W-1:0] pad_out;
		logic [FIELD_W-1:0] pad_oe;
		logic [FIELD_W-1:0] pull_up_en;
		logic [FIELD_W-1:0] pull_down_en;
	} gpc_rsp_t;

	// Result of decoding one word address.
	typedef struct packed {
		logic       mapped;
		logic       fsel;
		logic       set;
		logic       clr;
		logic       lev;
		logic       pud;
		logic       pudclk;
		logic       pup;
		logic       half;
		logic [2:0] fsel_word;
		logic [1:0] pup_word;
	} gpc_dec_t;

endpackage

// File: rtl/gpc_decode.sv
// ----------------------------------------------------------------------------
// GPIO pin controller address decoder
// Classifies a word address against the register map and the selected
// pull scheme.
// ----------------------------------------------------------------------------
module gpc_decode import gpc_pkg::*; #(
	parameter int NUM_PINS = 58
) (
	input  logic [ADDR_W-1:0] word_addr,
	input  logic              pull_scheme,
	output gpc_dec_t          dec
);

	localparam int FSEL_WORDS = (NUM_PINS + 9) / 10;
	localparam int PUP_WORDS  = (NUM_PINS + 15) / 16;

	logic       pup_range;
	logic [6:0] pup_off;

	assign pup_off   = 7'(word_addr) - 7'(W_PUP0);
	assign pup_range = (word_addr >= W_PUP0) && (pup_off < 7'(PUP_WORDS));

	always_comb begin
		dec           = '0;
		dec.fsel_word = word_addr[2:0];
		dec.pup_word  = pup_off[1:0];
		dec.half      = (word_addr == W_SET1) || (word_addr == W_CLR1) ||
		                (word_addr == W_LEV1) || (word_addr == W_PUDCLK1);
		if (7'(word_addr) < 7'(FSEL_WORDS)) begin
			dec.fsel = 1'b1;
		end else if (word_addr == W_SET0 || word_addr == W_SET1) begin
			dec.set = 1'b1;
		end else if (word_addr == W_CLR0 || word_addr == W_CLR1) begin
			dec.clr = 1'b1;
		end else if (word_addr == W_LEV0 || word_addr == W_LEV1) begin
			dec.lev = 1'b1;
		end else if (!pull_scheme && word_addr == W_PUD) begin
			dec.pud = 1'b1;
		end else if (!pull_scheme && (word_addr == W_PUDCLK0 || word_addr == W_PUDCLK1)) begin
			dec.pudclk = 1'b1;
		end else if (pull_scheme && pup_range) begin
			dec.pup = 1'b1;
		end
		dec.mapped = dec.fsel | dec.set | dec.clr | dec.lev | dec.pud | dec.pudclk | dec.pup;
	end

endmodule

// File: rtl/gpio_pin_controller.sv
// ----------------------------------------------------------------------------
// GPIO pin controller: input register, then state update and result register.
// Throughput one request per cycle unless out_ready stalls a held response.
// Reset clears all pin state, pull control and sets the global pull scheme register.
// ----------------------------------------------------------------------------
module gpio_pin_controller import gpc_pkg::*; #(
	parameter int NUM_PINS = 58
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  logic     in_valid,
	output logic     in_ready,
	input  gpc_req_t in_req,
	output logic     out_valid,
	input  logic     out_ready,
	output gpc_rsp_t out_rsp
);

	// Pins that exist; level reads and latch updates are masked with this.
	localparam logic [MAX_PINS-1:0] PIN_MASK = (NUM_PINS >= MAX_PINS) ? {MAX_PINS{1'b1}} :
	                                           ((MAX_PINS'(1) << NUM_PINS) - MAX_PINS'(1));

	// Configuration: the pull scheme register.
	logic pull_scheme_q;

	// Request stage.
	logic     valid_s1;
	gpc_req_t req_s1;

	// Response register.
	logic     out_valid_q;
	gpc_rsp_t rsp_q;

	// Pin state.
	logic [FSEL_W-1:0]   fsel_q [NUM_PINS];
	logic [PULL_W-1:0]   pull_q [NUM_PINS];
	logic [NUM_PINS-1:0] latch_q;
	logic [PULL_W-1:0]   pud_q;

	// Next state.
	logic [FSEL_W-1:0]   fsel_d [NUM_PINS];
	logic [PULL_W-1:0]   pull_d [NUM_PINS];
	logic [NUM_PINS-1:0] latch_d;
	logic [PULL_W-1:0]   pud_d;

	logic                fire_s1;
	logic                wr_s1;
	gpc_dec_t            dec;
	logic [MAX_PINS-1:0] word_mask;
	logic [PULL_W-1:0]   pud_swapped;
	logic [NUM_PINS-1:0] oe_v;
	logic [NUM_PINS-1:0] pu_v;
	logic [NUM_PINS-1:0] pd_v;

	// Packed views of the state for word reads.
	logic [FSEL_W*FSEL_PAD_PINS-1:0] fsel_pad;
	logic [PULL_W*MAX_PINS-1:0]      pull_pad;
	logic [MAX_PINS-1:0]             lev_pad;
	logic [DATA_W-1:0]               read_data;

	// A request leaves the first stage whenever the response register is
	// free or is being emptied in the same cycle; this keeps one request
	// per cycle flowing without a combinational path from out_ready to
	// any output but in_ready.
	assign fire_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire_s1;
	assign out_valid = out_valid_q;
	assign out_rsp   = rsp_q;
	assign wr_s1     = (req_s1.req_type == REQ_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pull_scheme_q <= 1'b1;
		end else if (cfg_we) begin
			pull_scheme_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_req;
		end
	end

	gpc_decode #(
		.NUM_PINS (NUM_PINS)
	) u_decode (
		.word_addr   (req_s1.word_addr),
		.pull_scheme (pull_scheme_q),
		.dec         (dec)
	);

	// The set, clear and pull clock words address one half of the pins,
	// so the data word is placed on the low or high 32 pins.
	assign word_mask = (dec.half ? {req_s1.write_data, 32'b0} : {32'b0, req_s1.write_data}) &
	                   PIN_MASK;

	// The legacy control word codes down as 1 and up as 2; the stored
	// per-pin code is the other way round, so the two bits are swapped.
	assign pud_swapped = {pud_q[0], pud_q[1]};

	always_comb begin
		latch_d = latch_q;
		pud_d   = pud_q;
		if (fire_s1 && wr_s1) begin
			if (dec.set) begin
				latch_d = latch_q | word_mask[NUM_PINS-1:0];
			end else if (dec.clr) begin
				latch_d = latch_q & ~word_mask[NUM_PINS-1:0];
			end
			if (dec.pud) begin
				pud_d = req_s1.write_data[PULL_W-1:0] & PULL_MASK;
			end
		end
	end

	for (genvar g = 0; g < NUM_PINS; g++) begin : g_pin
		localparam int FWORD = g / FSEL_PINS_PER_WORD;
		localparam int FBIT  = FSEL_W * (g % FSEL_PINS_PER_WORD);
		localparam int PWORD = g / PULL_PINS_PER_WORD;
		localparam int PBIT  = PULL_W * (g % PULL_PINS_PER_WORD);

		logic fsel_hit;
		logic pup_hit;
		logic clk_hit;

		assign fsel_hit = fire_s1 && wr_s1 && dec.fsel && (dec.fsel_word == 3'(FWORD));
		assign pup_hit  = fire_s1 && wr_s1 && dec.pup && (dec.pup_word == 2'(PWORD));
		assign clk_hit  = fire_s1 && wr_s1 && dec.pudclk && word_mask[g];

		assign fsel_d[g] = fsel_hit ? (req_s1.write_data[FBIT +: FSEL_W] & FSEL_FULL) : fsel_q[g];
		assign pull_d[g] = pup_hit ? (req_s1.write_data[PBIT +: PULL_W] & PULL_MASK) :
		                   clk_hit ? pud_swapped : pull_q[g];

		// Outputs reflect the state as it stands after this request.
		assign oe_v[g] = (fsel_d[g] == FSEL_OUTPUT);
		assign pu_v[g] = (pull_d[g] == PULL_UP);
		assign pd_v[g] = (pull_d[g] == PULL_DOWN);

		assign fsel_pad[FSEL_W*g +: FSEL_W] = fsel_q[g];
		assign pull_pad[PULL_W*g +: PULL_W] = pull_q[g];
	end

	// Pins beyond the configured count read as zero.
	if (NUM_PINS < FSEL_PAD_PINS) begin : g_fsel_fill
		assign fsel_pad[FSEL_W*FSEL_PAD_PINS-1:FSEL_W*NUM_PINS] = '0;
	end
	if (NUM_PINS < MAX_PINS) begin : g_pull_fill
		assign pull_pad[PULL_W*MAX_PINS-1:PULL_W*NUM_PINS] = '0;
	end

	assign lev_pad = MAX_PINS'(req_s1.pad_levels) & PIN_MASK;

	// Reads see the state before the request; writes always return zero,
	// as do unmapped words and the write-only set, clear and clock words.
	always_comb begin
		read_data = '0;
		if (!wr_s1) begin
			if (dec.fsel) begin
				read_data = {2'b0, fsel_pad[8'(dec.fsel_word) * 8'd30 +: 30]};
			end else if (dec.lev) begin
				read_data = dec.half ? lev_pad[63:32] : lev_pad[31:0];
			end else if (dec.pud) begin
				read_data = {30'b0, pud_q};
			end else if (dec.pup) begin
				read_data = pull_pad[{dec.pup_word, 5'b0} +: DATA_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q  <= '{default: '0};
			pull_q  <= '{default: '0};
			latch_q <= '0;
			pud_q   <= '0;
		end else if (fire_s1) begin
			fsel_q  <= fsel_d;
			pull_q  <= pull_d;
			latch_q <= latch_d;
			pud_q   <= pud_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q.read_data    <= read_data;
			rsp_q.unmapped     <= !dec.mapped;
			rsp_q.pad_out      <= FIELD_W'(MAX_PINS'(latch_d));
			rsp_q.pad_oe       <= FIELD_W'(MAX_PINS'(oe_v));
			rsp_q.pull_up_en   <= FIELD_W'(MAX_PINS'(pu_v));
			rsp_q.pull_down_en <= FIELD_W'(MAX_PINS'(pd_v));
		end
	end

`ifndef ASSERT_OFF
	// With the response register empty the first stage always drains.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("request stage stalled with an empty response register");

	// An unmapped word never returns data.
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_q.unmapped) |-> (rsp_q.read_data == '0))
		else $error("unmapped access returned non-zero read data");

	// A pin is never pulled both ways at once.
	a_pull_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((rsp_q.pull_up_en & rsp_q.pull_down_en) == '0))
		else $error("pin has pull-up and pull-down enabled together");

	// A write response always carries zero read data.
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && wr_s1) |=> (rsp_q.read_data == '0))
		else $error("write access returned non-zero read data");
`endif

endmodule
